// File: hdl/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg: shared types and constants of the bloom filter
// hash constants, controller states and controller/datapath command structs
// ----------------------------------------------------------------------------
package bfiq_pkg;

    localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
    localparam logic [31:0] HASH_MUL  = 32'hc6a4a793;

    localparam logic CFG_ACTIVE_BITS = 1'b0;
    localparam logic CFG_PROBE_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MIX,
        S_PSETUP,
        S_MOD,
        S_MEMRD,
        S_MEMCHK,
        S_NEXT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // write zero at clear address, advance
        logic take_item;  // absorb input item
        logic mul_go;     // register product of mix input
        logic mix_tail;   // finish multiply with >>24 (else >>16)
        logic mix_word;   // finish multiply
        logic probe_init; // load probe hash, delta and count
        logic mod_start;  // start modulo of probe hash
        logic mod_step;   // one modulo step
        logic mem_rd;     // issue memory read at probe position
        logic mem_chk;    // check / set the probed bit
        logic probe_next; // advance probe hash
        logic out_load;   // capture result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic need_mul;   // item just taken needs a word multiply
        logic key_end;    // item just taken completes a key
        logic tail_pend;  // tail bytes pending at key end
        logic mod_done;
        logic probes_done;
    } t_status;

endpackage

// File: hdl/bfiq_ram.sv
// ----------------------------------------------------------------------------
// bfiq_ram: generic single-port ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hdl/bfiq_ctrl.sv
// ----------------------------------------------------------------------------
// bfiq_ctrl: controller of the bloom filter
// sequences clearing, hashing, probing and the result transfer
// ----------------------------------------------------------------------------
module bfiq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  bfiq_pkg::t_status i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output bfiq_pkg::t_cmd    o_cmd
);
    bfiq_pkg::t_state r_state, n_state;
    logic             r_tail, n_tail;
    logic             r_end, n_end;
    logic             r_valid, n_valid;

    logic take;
    assign take = (r_state == bfiq_pkg::S_IDLE) && i_valid;

    // next state
    always_comb begin
        n_state = r_state;
        n_tail  = r_tail;
        n_end   = r_end;
        n_valid = r_valid;
        if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            bfiq_pkg::S_CLEAR: if (i_status.clear_done) n_state = bfiq_pkg::S_IDLE;
            bfiq_pkg::S_IDLE: begin
                if (take) begin
                    n_tail = i_status.tail_pend;
                    n_end  = i_status.key_end;
                    if (i_status.need_mul) begin
                        n_state = bfiq_pkg::S_MUL;
                        n_tail  = 1'b0;
                    end else if (i_status.key_end && i_status.tail_pend) begin
                        n_state = bfiq_pkg::S_MUL;
                    end else if (i_status.key_end) begin
                        n_state = bfiq_pkg::S_PSETUP;
                    end
                end
            end
            bfiq_pkg::S_MUL: n_state = bfiq_pkg::S_MIX;
            bfiq_pkg::S_MIX: begin
                if (!r_end) begin
                    n_state = bfiq_pkg::S_IDLE;
                end else if (!r_tail && i_status.tail_pend) begin
                    n_tail  = 1'b1;
                    n_state = bfiq_pkg::S_MUL;
                end else begin
                    n_state = bfiq_pkg::S_PSETUP;
                end
            end
            bfiq_pkg::S_PSETUP: n_state = bfiq_pkg::S_MOD;
            bfiq_pkg::S_MOD:  if (i_status.mod_done) n_state = bfiq_pkg::S_MEMRD;
            bfiq_pkg::S_MEMRD:  n_state = bfiq_pkg::S_MEMCHK;
            bfiq_pkg::S_MEMCHK: n_state = bfiq_pkg::S_NEXT;
            bfiq_pkg::S_NEXT: n_state = i_status.probes_done ? bfiq_pkg::S_OUT : bfiq_pkg::S_MOD;
            bfiq_pkg::S_OUT: begin
                if (!r_valid) begin
                    n_valid = 1'b1;
                    n_state = bfiq_pkg::S_IDLE;
                end
            end
            default: n_state = bfiq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.clr_step   = (r_state == bfiq_pkg::S_CLEAR) && !i_status.clear_done;
        o_cmd.take_item  = take;
        o_cmd.mul_go     = (r_state == bfiq_pkg::S_MUL);
        o_cmd.mix_word   = (r_state == bfiq_pkg::S_MIX);
        o_cmd.mix_tail   = r_tail;
        o_cmd.probe_init = (r_state == bfiq_pkg::S_PSETUP);
        o_cmd.mod_start  = (r_state == bfiq_pkg::S_PSETUP) || (r_state == bfiq_pkg::S_NEXT);
        o_cmd.mod_step   = (r_state == bfiq_pkg::S_MOD);
        o_cmd.mem_rd     = (r_state == bfiq_pkg::S_MEMRD);
        o_cmd.mem_chk    = (r_state == bfiq_pkg::S_MEMCHK);
        o_cmd.probe_next = (r_state == bfiq_pkg::S_NEXT);
        o_cmd.out_load   = (r_state == bfiq_pkg::S_OUT) && !r_valid;
        o_in_stall       = (r_state != bfiq_pkg::S_IDLE);
        o_out_valid      = r_valid;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfiq_pkg::S_CLEAR;
            r_tail  <= 1'b0;
            r_end   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
            r_end   <= n_end;
            r_valid <= n_valid;
        end
    end
endmodule

// File: hdl/bfiq_dp.sv
// ----------------------------------------------------------------------------
// bfiq_dp: datapath of the bloom filter
// byte hashing, bit-serial modulo, probe stepping and the bit memory
// ----------------------------------------------------------------------------
module bfiq_dp #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_PROBES  = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfiq_pkg::t_cmd    i_cmd,
    input  logic              i_op,
    input  logic [7:0]        i_key_byte,
    input  logic [15:0]       i_key_length,
    input  logic              i_last_byte,
    input  logic [16:0]       i_active_bits,
    input  logic [4:0]        i_probe_count,
    output bfiq_pkg::t_status o_status,
    output logic              o_done_op,
    output logic              o_may_match
);
    localparam int AW = $clog2(FILTER_BITS);
    localparam int MW = AW + 1;

    logic [31:0] r_hash, r_pend_h, r_prod, r_ph, r_delta;
    logic [23:0] r_pend;
    logic [1:0]  r_biw;
    logic        r_inside, r_op, r_all;
    logic [4:0]  r_cnt;
    logic [AW:0] r_clr;
    logic [MW-1:0] r_mod, r_rem;
    logic [5:0]  r_mbit;
    logic        r_mod_busy;
    logic [AW-1:0] r_pos;

    // clamped modulus and probe count
    logic [MW-1:0] mod_c;
    logic [4:0]    cnt_c;
    always_comb begin
        if (i_active_bits == 17'd0) mod_c = MW'(1);
        else if (32'(i_active_bits) > 32'(FILTER_BITS)) mod_c = MW'(FILTER_BITS);
        else mod_c = MW'(i_active_bits);
        if (i_probe_count == 5'd0) cnt_c = 5'd1;
        else if (32'(i_probe_count) > 32'(MAX_PROBES)) cnt_c = 5'(MAX_PROBES);
        else cnt_c = i_probe_count;
    end

    // hash start for a new key
    logic [31:0] seed_h, cur_h;
    logic [23:0] cur_p;
    logic [1:0]  cur_b;
    assign seed_h = bfiq_pkg::HASH_SEED ^ 32'(32'(i_key_length) * bfiq_pkg::HASH_MUL);
    assign cur_h  = r_inside ? r_hash : seed_h;
    assign cur_p  = r_inside ? r_pend : 24'd0;
    assign cur_b  = r_inside ? r_biw : 2'd0;

    logic empty_key;
    assign empty_key = !r_inside && (i_key_length == 16'd0);

    // tail bytes: judged on the item being taken, else on the stored count
    assign o_status.need_mul  = !empty_key && (cur_b == 2'd3);
    assign o_status.key_end   = empty_key || i_last_byte;
    assign o_status.tail_pend = i_cmd.take_item ? (!empty_key && (cur_b != 2'd3))
                                                : (r_biw != 2'd0);
    assign o_status.clear_done = (r_clr == MW'(FILTER_BITS));
    assign o_status.mod_done  = !r_mod_busy && !i_cmd.mod_start;
    assign o_status.probes_done = (r_cnt == 5'd0);

    logic [31:0] mix_in, mixed;
    assign mix_in = i_cmd.mix_tail ? (r_hash + 32'(r_pend)) : r_pend_h;
    assign mixed  = i_cmd.mix_tail ? (r_prod ^ (r_prod >> 24)) : (r_prod ^ (r_prod >> 16));

    // modulo step: one quotient bit per cycle
    logic [MW:0] trial;
    assign trial = {r_rem, r_ph[r_mbit[4:0]]} - {1'b0, r_mod};

    // bit memory, read addressed straight from the remainder
    logic          ram_we, ram_rd, ram_wd;
    logic [AW-1:0] ram_a;
    assign ram_we = i_cmd.clr_step || (i_cmd.mem_chk && !r_op);
    assign ram_a  = i_cmd.clr_step ? r_clr[AW-1:0] :
                    (i_cmd.mem_rd ? r_rem[AW-1:0] : r_pos);
    assign ram_wd = !i_cmd.clr_step;
    bfiq_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_a), .i_wdata(ram_wd), .o_rdata(ram_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_inside   <= 1'b0;
            r_biw      <= 2'd0;
            r_mod_busy <= 1'b0;
            r_cnt      <= 5'd0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.take_item) begin
                if (empty_key || i_last_byte) begin
                    r_inside <= 1'b0;
                end else begin
                    r_inside <= 1'b1;
                end
                if (!empty_key) r_biw <= cur_b + 2'd1;
            end
            if (i_cmd.probe_init) begin
                r_biw <= 2'd0;
                r_cnt <= cnt_c;
            end
            if (i_cmd.mod_start) begin
                r_mod_busy <= 1'b1;
            end else if (i_cmd.mod_step && r_mbit == 6'd0) begin
                r_mod_busy <= 1'b0;
            end
            if (i_cmd.mem_chk) r_cnt <= r_cnt - 5'd1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_op       <= i_op;
            r_hash     <= cur_h;
            if (!empty_key) begin
                if (cur_b == 2'd3) begin
                    r_pend_h <= cur_h + {i_key_byte, cur_p};
                    r_pend   <= 24'd0;
                end else begin
                    r_pend <= cur_p | (24'(i_key_byte) << {cur_b, 3'b000});
                end
            end else begin
                r_pend <= 24'd0;
            end
        end
        if (i_cmd.mul_go) r_prod <= 32'(mix_in * bfiq_pkg::HASH_MUL);
        if (i_cmd.mix_word) r_hash <= mixed;
        if (i_cmd.probe_init) begin
            r_ph    <= r_hash;
            r_delta <= {r_hash[16:0], r_hash[31:17]};
            r_all   <= 1'b1;
            r_mod   <= mod_c;
        end
        if (i_cmd.mod_start) begin
            r_rem  <= '0;
            r_mbit <= 6'd31;
        end else if (i_cmd.mod_step && r_mod_busy) begin
            if (!trial[MW]) r_rem <= trial[MW-1:0];
            else r_rem <= MW'({r_rem, r_ph[r_mbit[4:0]]});
            r_mbit <= r_mbit - 6'd1;
        end
        if (i_cmd.mem_rd) r_pos <= r_rem[AW-1:0];
        if (i_cmd.mem_chk && r_op && !ram_rd) r_all <= 1'b0;
        if (i_cmd.probe_next) r_ph <= r_ph + r_delta;
        if (i_cmd.out_load) begin
            o_done_op   <= r_op;
            o_may_match <= r_op & r_all;
        end
    end
endmodule

// File: hdl/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query: streamed-key bloom filter, insert and query
// murmur-like hashing of key bytes, double-hashed probes into a bit memory
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  input     | i_valid, o_stall, i_op, i_key_byte, ...   | in
//  result    | o_valid, i_stall, o_done_op, o_may_match  | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data| in
//
// a plain byte is only taken; a byte closing a word is taken, multiplied and mixed
// key end adds a multiply and mix for a closing word or tail, a setup step, then
// for each probe a serial modulo, a read, a check and a step, and then
// an output step; the input is stalled until the result has been loaded
// after reset the bit memory is cleared address by address, input is stalled
// a waiting result holds only the output cycle of the next key
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_PROBES  = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_key_byte,
    input  logic [15:0] i_key_length,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_done_op,
    output logic        o_may_match,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    bfiq_pkg::t_cmd    cmd;
    bfiq_pkg::t_status status;
    logic [16:0] r_active_bits;
    logic [4:0]  r_probe_count;

    // configuration transfer
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bits <= 17'd65536;
            r_probe_count <= 5'd6;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bfiq_pkg::CFG_ACTIVE_BITS: r_active_bits <= i_cfg_data;
                bfiq_pkg::CFG_PROBE_COUNT: r_probe_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    bfiq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_stall(i_stall),
        .i_status(status), .o_in_stall(o_stall), .o_out_valid(o_valid), .o_cmd(cmd)
    );

    bfiq_dp #(.FILTER_BITS(FILTER_BITS), .MAX_PROBES(MAX_PROBES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_op(i_op),
        .i_key_byte(i_key_byte), .i_key_length(i_key_length), .i_last_byte(i_last_byte),
        .i_active_bits(r_active_bits), .i_probe_count(r_probe_count),
        .o_status(status), .o_done_op(o_done_op), .o_may_match(o_may_match)
    );

    // an insert never reports a match
    a_ins_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_op |-> !o_may_match) else $error("insert reported match");
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_done_op) && $stable(o_may_match))
        else $error("stalled result changed");
    // a memory check always follows a read
    a_rd_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_rd |=> cmd.mem_chk) else $error("memory check missing");
endmodule
